[design/ffha_pkg.sv]
// Shared types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned HEAP_BYTES = 65536;
  localparam int unsigned GRAN_BYTES = 8;
  localparam int unsigned SLOTS      = HEAP_BYTES / GRAN_BYTES;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned LINK_W     = IDX_W + 1;
  localparam int unsigned SIZE_W     = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned REAL_W     = SIZE_W + 1;
  localparam int unsigned SPLIT_MIN  = 16;
  localparam int unsigned MIN_HEAP   = 64;

  localparam logic [LINK_W-1:0] END_LINK  = LINK_W'(SLOTS);
  localparam logic [SIZE_W-1:0] HEAP_MAX  = SIZE_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] HEAP_MIN  = SIZE_W'(MIN_HEAP);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  // One block header: link to next free block and block size in bytes
  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // Configuration strobe towards the sequencer
  typedef struct packed {
    logic              we;
    logic [SIZE_W-1:0] heap;
  } cfg_t;

  // Header store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    hdr_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Round down to the granule and clamp into the legal heap range
  function automatic logic [SIZE_W-1:0] eff_heap(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] h;
    h = {v[SIZE_W-1:3], 3'b000};
    if (h < HEAP_MIN) h = HEAP_MIN;
    if (h > HEAP_MAX) h = HEAP_MAX;
    return h;
  endfunction

endpackage

[design/ffha_if.sv]
// Request and response channel interfaces of the heap allocator.
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] request_size;
  logic [15:0] block_address;

  modport source (output valid, command, request_size, block_address, input ready);
  modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_offset;
  logic [1:0]  status;
  logic [16:0] free_bytes;

  modport source (output valid, payload_offset, status, free_bytes, input ready);
  modport sink   (input valid, payload_offset, status, free_bytes, output ready);
endinterface

[design/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator: register port, header store, sequencer.
//
// Requests arrive as words on req_i (valid/ready): command 0 allocates
// request_size bytes, command 1 frees the block at block_address. Each request
// gives exactly one word on rsp_o: payload offset, status and free byte count.
// The heap_size register (byte address 0, APB write in setup plus access cycle)
// reinitialises the heap to one free block; write it only while idle.
// One request is worked at a time. An allocate walks the free list from the
// header store, one header read per free block visited, then writes the
// split-off remainder, the allocated header and the previous link; a free reads
// the freed header, walks the free blocks below it, then merges with adjacent
// free blocks and rewrites their headers. A request rejected on its fields
// alone reads no header; a free rejected on its header stops after that read.
// The finished word sits in an output register; a new request is taken while
// it waits, and a stalled receiver holds back only the next completion.
// After reset the block writes the first header in S_INIT, then the
// heap holds 65536 free bytes.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ffha_req_if.sink    req_i,
  ffha_rsp_if.source  rsp_o
);

  localparam int unsigned SW = ffha_pkg::SIZE_W;

  logic [SW-1:0]      heap_size_q;
  logic               reg_hit;
  ffha_pkg::cfg_t     cfg;
  ffha_pkg::ram_req_t ram_req;
  ffha_pkg::hdr_t     ram_rdata;

  // Decode the register write
  assign reg_hit  = (paddr[2] == 1'b0);
  assign pready   = 1'b1;
  assign cfg.we   = psel && penable && pwrite && reg_hit;
  assign cfg.heap = ffha_pkg::eff_heap(pwdata[SW-1:0]);
  assign prdata   = reg_hit ? {{(32 - SW){1'b0}}, heap_size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size_q <= ffha_pkg::HEAP_MAX;
    end else if (cfg.we) begin
      heap_size_q <= pwdata[SW-1:0];
    end
  end

  ffha_ram #(
    .WIDTH ($bits(ffha_pkg::hdr_t)),
    .DEPTH (ffha_pkg::SLOTS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  ffha_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .ram_o   (ram_req),
    .rdata_i (ram_rdata)
  );

endmodule

[design/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/ffha_seq.sv]
// Sequencer that walks the free list and rewrites headers, reading or writing at most one header per state.
module ffha_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffha_pkg::cfg_t       cfg_i,
  ffha_req_if.sink             req_i,
  ffha_rsp_if.source           rsp_o,
  output ffha_pkg::ram_req_t   ram_o,
  input  ffha_pkg::hdr_t       rdata_i
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_FIN,
    A_RD, A_CHK, A_WREPL, A_WCUR, A_WPREV,
    F_HCHK, F_WRD, F_WCHK, F_CHECK, F_MERGE, F_WCUR, F_WG, F_WPREV
  } state_e;

  localparam int unsigned LW = ffha_pkg::LINK_W;
  localparam int unsigned IW = ffha_pkg::IDX_W;
  localparam int unsigned SW = ffha_pkg::SIZE_W;
  localparam int unsigned RW = ffha_pkg::REAL_W;

  state_e             state_q, state_d;
  logic [SW-1:0]      hs_q, hs_d;
  logic [LW-1:0]      head_q, head_d;
  logic [SW-1:0]      free_q, free_d;
  logic [LW-1:0]      cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic [SW-1:0]      prev_size_q, prev_size_d;
  logic [RW-1:0]      real_q, real_d;
  logic [SW-1:0]      take_q, take_d, s_q, s_d, s2_q, s2_d;
  logic [LW-1:0]      nxt_q, nxt_d, repl_q, repl_d, nl_q, nl_d;
  logic [IW-1:0]      g_q, g_d;
  logic               split_q, split_d, cur_adj_q, cur_adj_d, prev_adj_q, prev_adj_d;
  logic [15:0]        res_off_q, res_off_d;
  ffha_pkg::status_e  res_st_q, res_st_d;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_off_q, out_off_d;
  ffha_pkg::status_e  out_st_q, out_st_d;
  logic [SW-1:0]      out_free_q, out_free_d;

  logic [LW-1:0]      limit;
  logic [RW-1:0]      gend, pend, gbyte, cbyte;
  logic [15:0]        repl_sum;
  logic [SW-1:0]      taken;
  logic [RW-1:0]      free_sum;
  logic [IW:0]        g_sub;

  assign limit    = hs_q[SW-1:3];
  assign gbyte    = {2'b00, g_q, 3'b000};
  assign cbyte    = {2'b00, cur_q[IW-1:0], 3'b000};
  assign gend     = gbyte + {1'b0, s_q};
  assign pend     = {2'b00, prev_q[IW-1:0], 3'b000} + {1'b0, prev_size_q};
  assign repl_sum = {2'b00, cur_q} + {1'b0, real_q[RW-1:3]};
  assign taken    = split_q ? real_q[SW-1:0] : take_q;
  assign free_sum = {1'b0, free_q} + {1'b0, s_q};
  assign g_sub    = {1'b0, req_i.block_address[15:3]} - {{IW{1'b0}}, 1'b1};

  assign req_i.ready          = (state_q == S_IDLE) && !cfg_i.we;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.payload_offset = out_off_q;
  assign rsp_o.status         = out_st_q;
  assign rsp_o.free_bytes     = out_free_q;

  // Next state, header accesses and result
  always_comb begin
    state_d     = state_q;
    hs_d        = hs_q;
    head_d      = head_q;
    free_d      = free_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    prev_size_d = prev_size_q;
    real_d      = real_q;
    take_d      = take_q;
    s_d         = s_q;
    s2_d        = s2_q;
    nxt_d       = nxt_q;
    repl_d      = repl_q;
    nl_d        = nl_q;
    g_d         = g_q;
    split_d     = split_q;
    cur_adj_d   = cur_adj_q;
    prev_adj_d  = prev_adj_q;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_off_d   = out_off_q;
    out_st_d    = out_st_q;
    out_free_d  = out_free_q;
    ram_o       = '0;

    unique case (state_q)
      S_INIT: begin
        ram_o.we    = 1'b1;
        ram_o.wdata = '{next: ffha_pkg::END_LINK, size: hs_q};
        head_d      = '0;
        free_d      = hs_q;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_i.we) begin
          // Reinitialise to one free block covering the heap
          hs_d        = cfg_i.heap;
          ram_o.we    = 1'b1;
          ram_o.wdata = '{next: ffha_pkg::END_LINK, size: cfg_i.heap};
          head_d      = '0;
          free_d      = cfg_i.heap;
        end else if (req_i.valid) begin
          res_off_d = '0;
          res_st_d  = ffha_pkg::ST_DONE;
          prev_d    = ffha_pkg::END_LINK;
          cur_d     = head_q;
          steps_d   = '0;
          if (req_i.command == ffha_pkg::CMD_ALLOC) begin
            if (req_i.request_size == '0) begin
              res_st_d = ffha_pkg::ST_BAD;
              state_d  = S_FIN;
            end else begin
              real_d  = (({2'b00, req_i.request_size} + RW'(7)) & ~RW'(7)) + RW'(8);
              state_d = A_RD;
            end
          end else if (req_i.block_address == '0) begin
            state_d = S_FIN;
          end else if (req_i.block_address[2:0] != 3'b000 ||
                       {1'b0, g_sub} >= {1'b0, limit}) begin
            res_st_d = ffha_pkg::ST_BAD;
            state_d  = S_FIN;
          end else begin
            g_d         = g_sub[IW-1:0];
            ram_o.re    = 1'b1;
            ram_o.raddr = g_sub[IW-1:0];
            state_d     = F_HCHK;
          end
        end
      end
      A_RD: begin
        if (cur_q < ffha_pkg::END_LINK && steps_q < limit) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = cur_q[IW-1:0];
          state_d     = A_CHK;
        end else begin
          res_st_d = ffha_pkg::ST_NOFIT;
          state_d  = S_FIN;
        end
      end
      A_CHK: begin
        if ({1'b0, rdata_i.size} >= real_q) begin
          take_d  = rdata_i.size;
          nxt_d   = rdata_i.next;
          split_d = (rdata_i.size - real_q[SW-1:0] > SW'(ffha_pkg::SPLIT_MIN)) &&
                    (repl_sum < 16'(ffha_pkg::END_LINK));
          repl_d  = split_d ? repl_sum[LW-1:0] : rdata_i.next;
          state_d = A_WREPL;
        end else begin
          prev_d      = cur_q;
          prev_size_d = rdata_i.size;
          cur_d       = rdata_i.next;
          steps_d     = steps_q + 1'b1;
          state_d     = A_RD;
        end
      end
      A_WREPL: begin
        // On a split the remainder becomes a free block of its own
        if (split_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = repl_q[IW-1:0];
          ram_o.wdata = '{next: nxt_q, size: take_q - real_q[SW-1:0]};
        end
        state_d = A_WCUR;
      end
      A_WCUR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = cur_q[IW-1:0];
        ram_o.wdata = '{next: ffha_pkg::END_LINK, size: taken};
        free_d      = (free_q >= taken) ? free_q - taken : '0;
        res_off_d   = {cur_q[IW-1:0], 3'b000} + 16'd8;
        state_d     = A_WPREV;
      end
      A_WPREV: begin
        if (prev_q < ffha_pkg::END_LINK) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = prev_q[IW-1:0];
          ram_o.wdata = '{next: repl_q, size: prev_size_q};
        end else begin
          head_d = repl_q;
        end
        state_d = S_FIN;
      end
      F_HCHK: begin
        s_d = rdata_i.size;
        if (rdata_i.size == '0 || rdata_i.size[2:0] != 3'b000 ||
            gbyte + {1'b0, rdata_i.size} > {1'b0, hs_q}) begin
          res_st_d = ffha_pkg::ST_BAD;
          state_d  = S_FIN;
        end else begin
          state_d = F_WRD;
        end
      end
      F_WRD: begin
        if (cur_q < ffha_pkg::END_LINK && cur_q < {1'b0, g_q} && steps_q < limit) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = cur_q[IW-1:0];
          state_d     = F_WCHK;
        end else begin
          state_d = F_CHECK;
        end
      end
      F_WCHK: begin
        prev_d      = cur_q;
        prev_size_d = rdata_i.size;
        cur_d       = (rdata_i.next > ffha_pkg::END_LINK) ? ffha_pkg::END_LINK
                                                          : rdata_i.next;
        steps_d     = steps_q + 1'b1;
        state_d     = F_WRD;
      end
      F_CHECK: begin
        cur_adj_d  = (cur_q < ffha_pkg::END_LINK) && (gend == cbyte);
        prev_adj_d = (prev_q < ffha_pkg::END_LINK) && (pend == gbyte);
        if (cur_q == {1'b0, g_q} ||
            (prev_q < ffha_pkg::END_LINK && pend > gbyte) ||
            (cur_q < ffha_pkg::END_LINK && gend > cbyte)) begin
          res_st_d = ffha_pkg::ST_BAD;
          state_d  = S_FIN;
        end else begin
          ram_o.re    = cur_q < ffha_pkg::END_LINK;
          ram_o.raddr = cur_q[IW-1:0];
          state_d     = F_MERGE;
        end
      end
      F_MERGE: begin
        if (cur_adj_q) begin
          s2_d = s_q + rdata_i.size;
          nl_d = rdata_i.next;
        end else begin
          s2_d = s_q;
          nl_d = cur_q;
        end
        state_d = F_WCUR;
      end
      F_WCUR: begin
        // Absorb the following block when it is adjacent
        if (cur_adj_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = cur_q[IW-1:0];
          ram_o.wdata = '{next: ffha_pkg::END_LINK, size: '0};
        end
        state_d = F_WG;
      end
      F_WG: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = g_q;
        if (prev_adj_q) begin
          ram_o.wdata = '{next: ffha_pkg::END_LINK, size: '0};
        end else begin
          ram_o.wdata = '{next: nl_q, size: s2_q};
        end
        state_d     = F_WPREV;
      end
      F_WPREV: begin
        if (prev_adj_q) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = prev_q[IW-1:0];
          ram_o.wdata = '{next: nl_q, size: prev_size_q + s2_q};
        end else if (prev_q < ffha_pkg::END_LINK) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = prev_q[IW-1:0];
          ram_o.wdata = '{next: {1'b0, g_q}, size: prev_size_q};
        end else begin
          head_d = {1'b0, g_q};
        end
        free_d  = (free_sum > {1'b0, hs_q}) ? hs_q : free_sum[SW-1:0];
        state_d = S_FIN;
      end
      S_FIN: begin
        // Hand over the word once the output register is free or is being read out
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_st_d    = res_st_q;
          out_free_d  = free_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, heap bookkeeping and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      hs_q        <= ffha_pkg::HEAP_MAX;
      head_q      <= '0;
      free_q      <= ffha_pkg::HEAP_MAX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hs_q        <= hs_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    steps_q     <= steps_d;
    prev_size_q <= prev_size_d;
    real_q      <= real_d;
    take_q      <= take_d;
    s_q         <= s_d;
    s2_q        <= s2_d;
    nxt_q       <= nxt_d;
    repl_q      <= repl_d;
    nl_q        <= nl_d;
    g_q         <= g_d;
    split_q     <= split_d;
    cur_adj_q   <= cur_adj_d;
    prev_adj_q  <= prev_adj_d;
    res_off_q   <= res_off_d;
    res_st_q    <= res_st_d;
    out_off_q   <= out_off_d;
    out_st_q    <= out_st_d;
    out_free_q  <= out_free_d;
  end

endmodule
